// File: src/admm_eu_pkg.sv
`default_nettype none
// ============================================================================
// admm_eu_pkg
// Shared types and constants of the ADMM element-wise update block: opcodes,
// configuration register indexes, relaxation format and multiplier layout.
// ============================================================================
package admm_eu_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_PRIMAL_RHS,
        OP_CONSTRAINT_RHS,
        OP_PRIMAL_UPDATE,
        OP_CONSTRAINT_UPDATE
    } opcode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 33;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RELAXATION_FACTOR,
        REG_PRIMAL_REGULARIZATION
    } cfg_reg_t;

    // Relaxation factor alpha: unsigned, 24 fraction bits
    localparam int ALPHA_WIDTH = 25;
    localparam int ALPHA_FRAC  = 24;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE   = ALPHA_WIDTH'(1) << ALPHA_FRAC;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = 25'd26843546;

    // Regularization weight sigma
    localparam int SIGMA_WIDTH = 33;
    localparam logic [SIGMA_WIDTH-1:0] SIGMA_RESET = 33'd17;

    // Multiplier: limb size of the partial products and stage count
    localparam int LIMB_WIDTH  = 32;
    localparam int MUL_LATENCY = 5;

endpackage : admm_eu_pkg
`default_nettype wire

// File: src/admm_elementwise_update.sv
`default_nettype none
// ============================================================================
// admm_elementwise_update
// Element-wise kernel of an over-relaxed ADMM quadratic-program iteration:
// right-hand sides, relaxed primal update and clipped constraint update.
// ============================================================================
// The block takes one vector element per clock while in_ready is high and
// returns one result per element, in order. The datapath holds two
// five-stage limb multiplier banks in series: the relaxation, y/rho and
// sigma products first, then the rho product of the dual step after
// clipping. The pipeline advances as a whole; a two-entry output buffer
// keeps the input ready while one result waits, and the input stalls only
// once both entries are full. Values are signed fixed point with
// FRACTION_BITS fraction bits; every product rounds half away from zero
// and every sum saturates. Write the configuration registers only while no
// element is in flight.
module admm_elementwise_update #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Configuration write port
    input  wire logic                                   cfg_write,
    input  wire logic [admm_eu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [admm_eu_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // Input channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [1:0]                             opcode,
    input  wire logic signed [VALUE_WIDTH-1:0]          tilde_value,
    input  wire logic signed [VALUE_WIDTH-1:0]          prev_value,
    input  wire logic signed [VALUE_WIDTH-1:0]          dual_value,
    input  wire logic signed [VALUE_WIDTH-1:0]          linear_cost,
    input  wire logic [VALUE_WIDTH-2:0]                 penalty,
    input  wire logic [VALUE_WIDTH-2:0]                 penalty_inverse,
    input  wire logic signed [VALUE_WIDTH-1:0]          lower_bound,
    input  wire logic signed [VALUE_WIDTH-1:0]          upper_bound,
    input  wire logic                                   last_element,
    // Output channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [VALUE_WIDTH-1:0]               value_out,
    output logic signed [VALUE_WIDTH-1:0]               delta_out,
    output logic signed [VALUE_WIDTH-1:0]               dual_out,
    output logic                                        last_out
);
    import admm_eu_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int ML = MUL_LATENCY;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // Fields carried beside the first multiplier
    typedef struct packed {
        opcode_t                op;
        logic                   last;
        logic signed [VW-1:0]   dual;
        logic signed [VW-1:0]   prev;
        logic signed [VW-1:0]   cost;
        logic signed [VW-1:0]   lower;
        logic signed [VW-1:0]   upper;
        logic [VW-2:0]          rho;
    } side_t;

    // Fields of the add, clip and difference stages
    typedef struct packed {
        opcode_t                op;
        logic                   last;
        logic signed [VW-1:0]   dual;
        logic signed [VW-1:0]   prev;
        logic signed [VW-1:0]   lower;
        logic signed [VW-1:0]   upper;
        logic [VW-2:0]          rho;
        logic signed [VW-1:0]   relaxed;
        logic signed [VW-1:0]   work;
        logic signed [VW-1:0]   value;
        logic signed [VW-1:0]   delta;
    } elem_t;

    // Fields carried beside the rho multiplier
    typedef struct packed {
        opcode_t                op;
        logic                   last;
        logic signed [VW-1:0]   dual;
        logic signed [VW-1:0]   value;
        logic signed [VW-1:0]   delta;
    } tail_side_t;

    // One result item
    typedef struct packed {
        logic signed [VW-1:0]   value;
        logic signed [VW-1:0]   delta;
        logic signed [VW-1:0]   dual;
        logic                   last;
    } result_t;

    function automatic logic signed [VW-1:0] sat_add(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1])
            return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat_sub(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1])
            return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] x);
        logic [VW-1:0] u;
        u = x;
        if (x[VW-1])
            u = (~u) + VW'(1);
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ALPHA_WIDTH-1:0] alpha_reg;
    logic [SIGMA_WIDTH-1:0] sigma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            sigma_reg <= SIGMA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RELAXATION_FACTOR:     alpha_reg <= cfg_data[ALPHA_WIDTH-1:0];
                REG_PRIMAL_REGULARIZATION: sigma_reg <= cfg_data[SIGMA_WIDTH-1:0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic advance;
    logic skid_valid_reg;

    assign advance  = !skid_valid_reg;
    assign in_ready = advance;

    // ------------------------------------------------------------------
    // Stage 1: capture the element, form operand magnitudes
    // ------------------------------------------------------------------
    logic                   s1_valid_reg;
    side_t                  s1_side_reg;
    side_t                  s1_side_next;
    logic [VW-1:0]          tilde_mag_reg;
    logic [VW-1:0]          prev_mag_reg;
    logic [VW-1:0]          dual_mag_reg;
    logic [VW-2:0]          rinv_reg;
    logic [ALPHA_WIDTH-1:0] keep_mag_reg;
    logic [ALPHA_WIDTH-1:0] keep_mag_next;
    logic                   tilde_neg_reg;
    logic                   prev_neg_reg;
    logic                   dual_neg_reg;
    logic                   keep_neg_reg;
    logic                   keep_neg_next;

    always_comb
    begin
        logic signed [ALPHA_WIDTH:0] one_minus;
        s1_side_next.op    = opcode_t'(opcode);
        s1_side_next.last  = last_element;
        s1_side_next.dual  = dual_value;
        s1_side_next.prev  = prev_value;
        s1_side_next.cost  = linear_cost;
        s1_side_next.lower = lower_bound;
        s1_side_next.upper = upper_bound;
        s1_side_next.rho   = penalty;

        // 1 - alpha kept exactly, as sign and magnitude
        one_minus = signed'({1'b0, ALPHA_ONE}) - signed'({1'b0, alpha_reg});
        if (one_minus[ALPHA_WIDTH])
            keep_mag_next = alpha_reg - ALPHA_ONE;
        else
            keep_mag_next = one_minus[ALPHA_WIDTH-1:0];
        keep_neg_next = one_minus[ALPHA_WIDTH] ^ prev_value[VW-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_side_reg   <= s1_side_next;
            tilde_mag_reg <= mag_of(tilde_value);
            prev_mag_reg  <= mag_of(prev_value);
            dual_mag_reg  <= mag_of(dual_value);
            rinv_reg      <= penalty_inverse;
            keep_mag_reg  <= keep_mag_next;
            tilde_neg_reg <= tilde_value[VW-1];
            prev_neg_reg  <= prev_value[VW-1];
            dual_neg_reg  <= dual_value[VW-1];
            keep_neg_reg  <= keep_neg_next;
        end
    end

    // ------------------------------------------------------------------
    // First multiplier bank: alpha*x~, (1-alpha)*prev, y/rho, sigma*prev
    // ------------------------------------------------------------------
    logic signed [VW-1:0] alpha_prod;
    logic signed [VW-1:0] keep_prod;
    logic signed [VW-1:0] rinv_prod;
    logic signed [VW-1:0] sigma_prod;

    admm_eu_mul #(
        .A_WIDTH     (ALPHA_WIDTH),
        .B_WIDTH     (VW),
        .SHIFT       (ALPHA_FRAC),
        .VALUE_WIDTH (VW)
    ) u_mul_alpha (
        .clk     (clk),
        .en      (advance),
        .a_mag   (alpha_reg),
        .b_mag   (tilde_mag_reg),
        .neg     (tilde_neg_reg),
        .product (alpha_prod)
    );

    admm_eu_mul #(
        .A_WIDTH     (ALPHA_WIDTH),
        .B_WIDTH     (VW),
        .SHIFT       (ALPHA_FRAC),
        .VALUE_WIDTH (VW)
    ) u_mul_keep (
        .clk     (clk),
        .en      (advance),
        .a_mag   (keep_mag_reg),
        .b_mag   (prev_mag_reg),
        .neg     (keep_neg_reg),
        .product (keep_prod)
    );

    admm_eu_mul #(
        .A_WIDTH     (VW - 1),
        .B_WIDTH     (VW),
        .SHIFT       (FRACTION_BITS),
        .VALUE_WIDTH (VW)
    ) u_mul_rinv (
        .clk     (clk),
        .en      (advance),
        .a_mag   (rinv_reg),
        .b_mag   (dual_mag_reg),
        .neg     (dual_neg_reg),
        .product (rinv_prod)
    );

    admm_eu_mul #(
        .A_WIDTH     (SIGMA_WIDTH),
        .B_WIDTH     (VW),
        .SHIFT       (FRACTION_BITS),
        .VALUE_WIDTH (VW)
    ) u_mul_sigma (
        .clk     (clk),
        .en      (advance),
        .a_mag   (sigma_reg),
        .b_mag   (prev_mag_reg),
        .neg     (prev_neg_reg),
        .product (sigma_prod)
    );

    // Carry the element beside the first bank
    side_t side_dly_reg  [ML];
    logic  side_vld_reg  [ML];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_dly_reg[0] <= s1_side_reg;
            for (int k = 1; k < ML; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // E1: relaxed sum and right-hand sides
    // ------------------------------------------------------------------
    elem_t e1_reg;
    elem_t e1_next;
    elem_t e2_reg;
    elem_t e2_next;
    elem_t e3_reg;
    elem_t e3_next;
    elem_t e4_reg;
    elem_t e4_next;
    logic  e1_valid_reg;
    logic  e2_valid_reg;
    logic  e3_valid_reg;
    logic  e4_valid_reg;

    always_comb
    begin
        side_t sd;
        sd = side_dly_reg[ML-1];
        e1_next.op      = sd.op;
        e1_next.last    = sd.last;
        e1_next.dual    = sd.dual;
        e1_next.prev    = sd.prev;
        e1_next.lower   = sd.lower;
        e1_next.upper   = sd.upper;
        e1_next.rho     = sd.rho;
        e1_next.relaxed = sat_add(alpha_prod, keep_prod);
        e1_next.work    = rinv_prod;
        e1_next.delta   = '0;
        if (sd.op == OP_PRIMAL_RHS)
            e1_next.value = sat_sub(sigma_prod, sd.cost);
        else
            e1_next.value = sat_sub(sd.prev, rinv_prod);
    end

    // E2: shifted point for clipping, primal step
    always_comb
    begin
        e2_next       = e1_reg;
        e2_next.work  = sat_add(e1_reg.relaxed, e1_reg.work);
        e2_next.delta = sat_sub(e1_reg.relaxed, e1_reg.prev);
        if (e1_reg.op == OP_PRIMAL_UPDATE)
            e2_next.value = e1_reg.relaxed;
    end

    // E3: clip to the bounds, upper bound wins when they cross
    always_comb
    begin
        logic above_upper;
        logic crossed;
        logic below_lower;
        above_upper = e2_reg.work > e2_reg.upper;
        crossed     = e2_reg.lower > e2_reg.upper;
        below_lower = e2_reg.work < e2_reg.lower;
        e3_next = e2_reg;
        if (above_upper || crossed)
            e3_next.work = e2_reg.upper;
        else if (below_lower)
            e3_next.work = e2_reg.lower;
    end

    // E4: take the clipped point as z and form relaxed - z
    always_comb
    begin
        e4_next      = e3_reg;
        e4_next.work = sat_sub(e3_reg.relaxed, e3_reg.work);
        if (e3_reg.op == OP_CONSTRAINT_UPDATE)
            e4_next.value = e3_reg.work;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            e4_reg <= e4_next;
        end
    end

    // ------------------------------------------------------------------
    // E5: operands of the rho multiplier
    // ------------------------------------------------------------------
    tail_side_t     rs_reg;
    tail_side_t     rs_next;
    logic           rs_valid_reg;
    logic [VW-2:0]  rho_in_reg;
    logic [VW-1:0]  diff_mag_reg;
    logic           diff_neg_reg;

    always_comb
    begin
        rs_next.op    = e4_reg.op;
        rs_next.last  = e4_reg.last;
        rs_next.dual  = e4_reg.dual;
        rs_next.value = e4_reg.value;
        rs_next.delta = e4_reg.delta;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_reg       <= rs_next;
            rho_in_reg   <= e4_reg.rho;
            diff_mag_reg <= mag_of(e4_reg.work);
            diff_neg_reg <= e4_reg.work[VW-1];
        end
    end

    logic signed [VW-1:0] rho_prod;

    admm_eu_mul #(
        .A_WIDTH     (VW - 1),
        .B_WIDTH     (VW),
        .SHIFT       (FRACTION_BITS),
        .VALUE_WIDTH (VW)
    ) u_mul_rho (
        .clk     (clk),
        .en      (advance),
        .a_mag   (rho_in_reg),
        .b_mag   (diff_mag_reg),
        .neg     (diff_neg_reg),
        .product (rho_prod)
    );

    // Carry the element beside the rho multiplier
    tail_side_t rs_dly_reg [ML];
    logic       rs_vld_reg [ML];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_dly_reg[0] <= rs_reg;
            for (int k = 1; k < ML; k++)
            begin
                rs_dly_reg[k] <= rs_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: dual step and result selection
    // ------------------------------------------------------------------
    result_t tail_reg;
    result_t tail_next;
    logic    tail_valid_reg;

    always_comb
    begin
        tail_side_t rd;
        rd = rs_dly_reg[ML-1];
        tail_next.value = rd.value;
        tail_next.last  = rd.last;
        tail_next.dual  = rd.dual;
        case (rd.op)
            OP_CONSTRAINT_UPDATE:
            begin
                tail_next.delta = rho_prod;
                tail_next.dual  = sat_add(rd.dual, rho_prod);
            end
            OP_PRIMAL_UPDATE:
                tail_next.delta = rd.delta;
            default:
                tail_next.delta = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            tail_reg <= tail_next;
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            e1_valid_reg   <= 1'b0;
            e2_valid_reg   <= 1'b0;
            e3_valid_reg   <= 1'b0;
            e4_valid_reg   <= 1'b0;
            rs_valid_reg   <= 1'b0;
            tail_valid_reg <= 1'b0;
            for (int k = 0; k < ML; k++)
            begin
                side_vld_reg[k] <= 1'b0;
                rs_vld_reg[k]   <= 1'b0;
            end
        end
        else if (advance)
        begin
            s1_valid_reg    <= in_valid;
            side_vld_reg[0] <= s1_valid_reg;
            rs_vld_reg[0]   <= rs_valid_reg;
            for (int k = 1; k < ML; k++)
            begin
                side_vld_reg[k] <= side_vld_reg[k-1];
                rs_vld_reg[k]   <= rs_vld_reg[k-1];
            end
            e1_valid_reg   <= side_vld_reg[ML-1];
            e2_valid_reg   <= e1_valid_reg;
            e3_valid_reg   <= e2_valid_reg;
            e4_valid_reg   <= e3_valid_reg;
            rs_valid_reg   <= e4_valid_reg;
            tail_valid_reg <= rs_vld_reg[ML-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_next;
    logic    load_out;
    logic    load_skid;
    logic    out_from_skid;
    logic    push;
    logic    pop;

    assign push = advance && tail_valid_reg;
    assign pop  = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            // Drain the skid entry once the output transfer completes
            if (pop)
            begin
                load_out        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= out_from_skid ? skid_reg : tail_reg;
        if (load_skid)
            skid_reg <= tail_reg;
    end

    assign out_valid = out_valid_reg;
    assign value_out = out_reg.value;
    assign delta_out = out_reg.delta;
    assign dual_out  = out_reg.dual;
    assign last_out  = out_reg.last;

endmodule : admm_elementwise_update
`default_nettype wire

// File: src/admm_eu_mul.sv
`default_nettype none
// ============================================================================
// admm_eu_mul
// Pipelined sign-magnitude fixed-point multiplier. Splits the operands into
// 32-bit limbs, sums the partial products, rounds half away from zero,
// saturates to the signed value range and applies the sign. Five stages.
// ============================================================================
module admm_eu_mul #(
    parameter int A_WIDTH     = 25,
    parameter int B_WIDTH     = 48,
    parameter int SHIFT       = 24,
    parameter int VALUE_WIDTH = 48
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [A_WIDTH-1:0]            a_mag,
    input  wire logic [B_WIDTH-1:0]            b_mag,
    input  wire logic                          neg,
    output logic signed [VALUE_WIDTH-1:0]      product
);
    import admm_eu_pkg::*;

    localparam int NA = (A_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
    localparam int NB = (B_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
    localparam int PW = A_WIDTH + B_WIDTH;
    localparam int EW = (NA + NB) * LIMB_WIDTH;
    localparam int MW = PW + 1 - SHIFT;
    localparam int CW = (MW > VALUE_WIDTH) ? MW : VALUE_WIDTH;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (SHIFT - 1);
    localparam logic [CW-1:0] POS_LIMIT = (CW'(1) << (VALUE_WIDTH - 1)) - CW'(1);
    localparam logic [CW-1:0] NEG_LIMIT = CW'(1) << (VALUE_WIDTH - 1);

    logic [NA*LIMB_WIDTH-1:0]   a_pad;
    logic [NB*LIMB_WIDTH-1:0]   b_pad;
    logic [2*LIMB_WIDTH-1:0]    pp_next [NA*NB];
    logic [2*LIMB_WIDTH-1:0]    pp_reg  [NA*NB];
    logic [PW-1:0]              sum_next;
    logic [PW-1:0]              sum_reg;
    logic [MW-1:0]              mag_next;
    logic [MW-1:0]              mag_reg;
    logic [VALUE_WIDTH-1:0]     sat_next;
    logic [VALUE_WIDTH-1:0]     sat_reg;
    logic [VALUE_WIDTH-1:0]     product_next;
    logic [VALUE_WIDTH-1:0]     product_reg;
    logic                       neg_pp_reg;
    logic                       neg_sum_reg;
    logic                       neg_mag_reg;
    logic                       neg_sat_reg;

    // Form limb partial products
    assign a_pad = (NA*LIMB_WIDTH)'(a_mag);
    assign b_pad = (NB*LIMB_WIDTH)'(b_mag);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i*NB+j] = a_pad[i*LIMB_WIDTH +: LIMB_WIDTH]
                                * b_pad[j*LIMB_WIDTH +: LIMB_WIDTH];
            end
        end
    end

    // Sum the partial products at their limb offsets
    always_comb
    begin
        logic [EW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (EW'(pp_reg[i*NB+j]) << (LIMB_WIDTH * (i + j)));
            end
        end
        sum_next = acc[PW-1:0];
    end

    // Round half away from zero and drop the fraction bits
    always_comb
    begin
        logic [PW:0] rnd;
        rnd = (PW + 1)'(sum_reg) + HALF;
        mag_next = rnd[PW:SHIFT];
    end

    // Clamp the magnitude to the range of the signed result
    always_comb
    begin
        logic [CW-1:0] mag_ext;
        logic [CW-1:0] limit;
        mag_ext = CW'(mag_reg);
        limit   = neg_mag_reg ? NEG_LIMIT : POS_LIMIT;
        sat_next = (mag_ext > limit) ? limit[VALUE_WIDTH-1:0] : mag_ext[VALUE_WIDTH-1:0];
    end

    // Apply the sign
    assign product_next = neg_sat_reg ? ((~sat_reg) + VALUE_WIDTH'(1)) : sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg      <= pp_next;
            neg_pp_reg  <= neg;
            sum_reg     <= sum_next;
            neg_sum_reg <= neg_pp_reg;
            mag_reg     <= mag_next;
            neg_mag_reg <= neg_sum_reg;
            sat_reg     <= sat_next;
            neg_sat_reg <= neg_mag_reg;
            product_reg <= product_next;
        end
    end

    assign product = signed'(product_reg);

endmodule : admm_eu_mul
`default_nettype wire

// File: tb/admm_eu_checker.sv
// ============================================================================
// admm_eu_checker
// Watches both channels of the ADMM element-wise update block, mirrors its
// configuration registers, predicts every result in fixed point and compares
// it field by field against what the block returns, in order.
// ============================================================================
module admm_eu_checker #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [admm_eu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [admm_eu_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [1:0]                              opcode,
    input  logic signed [VALUE_WIDTH-1:0]           tilde_value,
    input  logic signed [VALUE_WIDTH-1:0]           prev_value,
    input  logic signed [VALUE_WIDTH-1:0]           dual_value,
    input  logic signed [VALUE_WIDTH-1:0]           linear_cost,
    input  logic [VALUE_WIDTH-2:0]                  penalty,
    input  logic [VALUE_WIDTH-2:0]                  penalty_inverse,
    input  logic signed [VALUE_WIDTH-1:0]           lower_bound,
    input  logic signed [VALUE_WIDTH-1:0]           upper_bound,
    input  logic                                    last_element,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [VALUE_WIDTH-1:0]           value_out,
    input  logic signed [VALUE_WIDTH-1:0]           delta_out,
    input  logic signed [VALUE_WIDTH-1:0]           dual_out,
    input  logic                                    last_out,
    output int                                      fail_count,
    output int                                      in_flight
);

    import admm_eu_pkg::*;

    localparam logic signed [63:0] VALUE_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VALUE_MIN = -VALUE_MAX - 64'sd1;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic signed [VALUE_WIDTH-1:0] delta;
        logic signed [VALUE_WIDTH-1:0] dual;
        logic                          last;
    } update_result_t;

    logic [ALPHA_WIDTH-1:0] relaxation;
    logic [SIGMA_WIDTH-1:0] regularization;
    update_result_t         results_due[$];
    update_result_t         due;
    int                     mismatches = 0;

    assign fail_count = mismatches;

    // Clamp a wide intermediate to the value range
    function automatic logic signed [63:0] saturate_value(input logic signed [63:0] x);
        if (x > VALUE_MAX)
            return VALUE_MAX;
        if (x < VALUE_MIN)
            return VALUE_MIN;
        return x;
    endfunction

    // Exact product scaled down by 2^shift, rounded half away from zero, saturated
    function automatic logic signed [63:0] round_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int shift);
        logic [127:0]        mag_a;
        logic [127:0]        mag_b;
        logic [127:0]        mag;
        logic [127:0]        limit;
        logic                negative;
        logic signed [63:0]  r;
        negative = (a < 0) != (b < 0);
        mag_a = (a < 0) ? 128'(-a) : 128'(a);
        mag_b = (b < 0) ? 128'(-b) : 128'(b);
        mag = mag_a * mag_b;
        if (shift > 0)
            mag = (mag + (128'd1 << (shift - 1))) >> shift;
        limit = negative ? 128'(VALUE_MAX) + 128'd1 : 128'(VALUE_MAX);
        if (mag > limit)
            mag = limit;
        r = 64'(mag);
        return negative ? -r : r;
    endfunction

    // Work out the result of the element now on the input channel
    function automatic update_result_t compute_update();
        logic signed [63:0] tilde;
        logic signed [63:0] prev;
        logic signed [63:0] y;
        logic signed [63:0] cost;
        logic signed [63:0] rho;
        logic signed [63:0] rinv;
        logic signed [63:0] lo;
        logic signed [63:0] up;
        logic signed [63:0] alpha;
        logic signed [63:0] one_minus;
        logic signed [63:0] relaxed;
        logic signed [63:0] clipped;
        logic signed [63:0] value;
        logic signed [63:0] delta;
        logic signed [63:0] dual;
        update_result_t     r;
        tilde     = 64'(tilde_value);
        prev      = 64'(prev_value);
        y         = 64'(dual_value);
        cost      = 64'(linear_cost);
        rho       = 64'(penalty);
        rinv      = 64'(penalty_inverse);
        lo        = 64'(lower_bound);
        up        = 64'(upper_bound);
        alpha     = 64'(relaxation);
        one_minus = (64'sd1 <<< ALPHA_FRAC) - alpha;
        value     = 0;
        delta     = 0;
        dual      = y;
        case (opcode)
            OP_PRIMAL_RHS:
                value = saturate_value(
                    round_product(64'(regularization), prev, FRACTION_BITS) - cost);
            OP_CONSTRAINT_RHS:
                value = saturate_value(prev - round_product(rinv, y, FRACTION_BITS));
            default:
            begin
                relaxed = saturate_value(round_product(alpha, tilde, ALPHA_FRAC)
                                         + round_product(one_minus, prev, ALPHA_FRAC));
                if (opcode == OP_PRIMAL_UPDATE)
                begin
                    value = relaxed;
                    delta = saturate_value(relaxed - prev);
                end
                else
                begin
                    // Project onto the bounds; the upper bound wins when they cross
                    clipped = saturate_value(relaxed + round_product(rinv, y, FRACTION_BITS));
                    if (clipped < lo)
                        clipped = lo;
                    if (clipped > up)
                        clipped = up;
                    value = clipped;
                    delta = round_product(rho, saturate_value(relaxed - clipped),
                                          FRACTION_BITS);
                    dual  = saturate_value(y + delta);
                end
            end
        endcase
        r.value = value[VALUE_WIDTH-1:0];
        r.delta = delta[VALUE_WIDTH-1:0];
        r.dual  = dual[VALUE_WIDTH-1:0];
        r.last  = last_element;
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic signed [VALUE_WIDTH-1:0] want,
                               input logic signed [VALUE_WIDTH-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Mirror the registers, queue a prediction per input transfer, check each output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relaxation     <= ALPHA_RESET;
            regularization <= SIGMA_RESET;
            results_due.delete();
            in_flight      <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RELAXATION_FACTOR:     relaxation     <= cfg_data[ALPHA_WIDTH-1:0];
                    REG_PRIMAL_REGULARIZATION: regularization <= cfg_data[SIGMA_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                results_due.push_back(compute_update());
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result transfer: value_out=%0d, nothing in flight",
                           value_out);
                    mismatches++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("value_out", due.value, value_out);
                    check_field("delta_out", due.delta, delta_out);
                    check_field("dual_out", due.dual, dual_out);
                    check_field("last_out", VALUE_WIDTH'(due.last), VALUE_WIDTH'(last_out));
                end
            end
            in_flight <= results_due.size();
        end
    end

endmodule : admm_eu_checker

// File: tb/admm_elementwise_update_tb.sv
// ============================================================================
// admm_elementwise_update_tb
// Drives vector elements of every opcode into the ADMM element-wise update
// block under bursty input and a stalling output, across several relaxation
// and regularization settings; the checker predicts and compares the results.
// ============================================================================
module admm_elementwise_update_tb;

    import admm_eu_pkg::*;

    localparam int VW          = 48;
    localparam int FB          = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 3 * MUL_LATENCY + 5;

    localparam logic signed [VW-1:0] MAX_VALUE = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN_VALUE = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_VALUE = VW'(1) << FB;
    localparam logic [VW-2:0]        RATE_MAX  = {(VW-1){1'b1}};

    typedef struct {
        opcode_t              op;
        logic signed [VW-1:0] tilde;
        logic signed [VW-1:0] prev;
        logic signed [VW-1:0] dual;
        logic signed [VW-1:0] cost;
        logic [VW-2:0]        rho;
        logic [VW-2:0]        rinv;
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] up;
        logic                 last;
    } element_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 opcode = '0;
    logic signed [VW-1:0]       tilde_value = '0;
    logic signed [VW-1:0]       prev_value = '0;
    logic signed [VW-1:0]       dual_value = '0;
    logic signed [VW-1:0]       linear_cost = '0;
    logic [VW-2:0]              penalty = '0;
    logic [VW-2:0]              penalty_inverse = '0;
    logic signed [VW-1:0]       lower_bound = '0;
    logic signed [VW-1:0]       upper_bound = '0;
    logic                       last_element = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [VW-1:0]       value_out;
    logic signed [VW-1:0]       delta_out;
    logic signed [VW-1:0]       dual_out;
    logic                       last_out;

    int fail_count;
    int in_flight;
    int quiet_cycles = 0;
    int ready_mode = 0;
    int ready_left = 0;

    always #5 clk = ~clk;

    admm_elementwise_update #(
        .VALUE_WIDTH   (VW),
        .FRACTION_BITS (FB)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .tilde_value     (tilde_value),
        .prev_value      (prev_value),
        .dual_value      (dual_value),
        .linear_cost     (linear_cost),
        .penalty         (penalty),
        .penalty_inverse (penalty_inverse),
        .lower_bound     (lower_bound),
        .upper_bound     (upper_bound),
        .last_element    (last_element),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value_out       (value_out),
        .delta_out       (delta_out),
        .dual_out        (dual_out),
        .last_out        (last_out)
    );

    admm_eu_checker #(
        .VALUE_WIDTH   (VW),
        .FRACTION_BITS (FB)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .tilde_value     (tilde_value),
        .prev_value      (prev_value),
        .dual_value      (dual_value),
        .linear_cost     (linear_cost),
        .penalty         (penalty),
        .penalty_inverse (penalty_inverse),
        .lower_bound     (lower_bound),
        .upper_bound     (upper_bound),
        .last_element    (last_element),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value_out       (value_out),
        .delta_out       (delta_out),
        .dual_out        (dual_out),
        .last_out        (last_out),
        .fail_count      (fail_count),
        .in_flight       (in_flight)
    );

    // Output backpressure: pick a new stall style whenever the current one runs out
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(5, 60);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (ready_left % 3 != 0);
        endcase
    end

    // Watchdog: give up when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic element_t make_element(input opcode_t op,
                                              input logic signed [VW-1:0] tilde,
                                              input logic signed [VW-1:0] prev,
                                              input logic signed [VW-1:0] dual,
                                              input logic signed [VW-1:0] cost,
                                              input logic [VW-2:0] rho,
                                              input logic [VW-2:0] rinv,
                                              input logic signed [VW-1:0] lo,
                                              input logic signed [VW-1:0] up,
                                              input logic last);
        element_t e;
        e.op    = op;
        e.tilde = tilde;
        e.prev  = prev;
        e.dual  = dual;
        e.cost  = cost;
        e.rho   = rho;
        e.rinv  = rinv;
        e.lo    = lo;
        e.up    = up;
        e.last  = last;
        return e;
    endfunction

    // Mostly moderate magnitudes, sometimes full-range noise or an extreme code
    function automatic logic signed [VW-1:0] random_value();
        logic signed [VW-1:0] raw;
        raw = VW'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: return raw;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return MAX_VALUE;
                    1: return MIN_VALUE;
                    2: return '0;
                    3: return VW'(1);
                    default: return '1;
                endcase
            end
            default: return raw >>> $urandom_range(13, 28);
        endcase
    endfunction

    function automatic element_t random_element();
        element_t             e;
        logic [63:0]          rate;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        e.op    = opcode_t'($urandom_range(0, 3));
        e.tilde = random_value();
        e.prev  = random_value();
        e.dual  = random_value();
        e.cost  = random_value();
        // Penalty pair: mostly a matching reciprocal, sometimes zero, all-ones or unrelated
        case ($urandom_range(0, 7))
            0:
            begin
                e.rho  = '0;
                e.rinv = '0;
            end
            1:
            begin
                e.rho  = (VW-1)'({$urandom, $urandom});
                e.rinv = (VW-1)'({$urandom, $urandom});
            end
            2:
            begin
                e.rho  = RATE_MAX;
                e.rinv = RATE_MAX;
            end
            default:
            begin
                rate   = $urandom_range(1 << 16, 1 << 30);
                e.rho  = (VW-1)'(rate);
                e.rinv = (VW-1)'(((64'd1 << (2 * FB)) + (rate >> 1)) / rate);
            end
        endcase
        a = random_value();
        b = random_value();
        case ($urandom_range(0, 7))
            0:
            begin
                e.lo = MIN_VALUE;
                e.up = MAX_VALUE;
            end
            1:
            begin
                e.lo = MIN_VALUE;
                e.up = (a > b) ? a : b;
            end
            2:
            begin
                e.lo = (a < b) ? a : b;
                e.up = MAX_VALUE;
            end
            3:
            begin
                e.lo = (a > b) ? a : b;
                e.up = (a < b) ? a : b;
            end
            4:
            begin
                e.lo = a;
                e.up = a;
            end
            default:
            begin
                e.lo = (a < b) ? a : b;
                e.up = (a > b) ? a : b;
            end
        endcase
        e.last = 1'b0;
        return e;
    endfunction

    // Present one element and hold it until the transfer
    task automatic push_element(input element_t e);
        in_valid        <= 1'b1;
        opcode          <= e.op;
        tilde_value     <= e.tilde;
        prev_value      <= e.prev;
        dual_value      <= e.dual;
        linear_cost     <= e.cost;
        penalty         <= e.rho;
        penalty_inverse <= e.rinv;
        lower_bound     <= e.lo;
        upper_bound     <= e.up;
        last_element    <= e.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send random vectors in bursts separated by random gaps
    task automatic run_random_items(input int count);
        int       burst_left;
        int       gap;
        int       vector_left;
        element_t e;
        burst_left  = $urandom_range(1, 24);
        vector_left = $urandom_range(1, 16);
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            e = random_element();
            e.last = (vector_left == 1);
            vector_left = (vector_left == 1) ? $urandom_range(1, 16) : vector_left - 1;
            push_element(e);
            burst_left--;
        end
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [ALPHA_WIDTH-1:0] alpha,
                             input logic [SIGMA_WIDTH-1:0] sigma,
                             input int count);
        write_register(REG_RELAXATION_FACTOR, CFG_DATA_WIDTH'(alpha));
        write_register(REG_PRIMAL_REGULARIZATION, CFG_DATA_WIDTH'(sigma));
        run_random_items(count);
        drain_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed elements at the reset settings
        push_element(make_element(OP_PRIMAL_RHS, '0, ONE_VALUE, '0, ONE_VALUE >>> 1,
                                  '0, '0, '0, '0, 1'b0));
        push_element(make_element(OP_CONSTRAINT_RHS, '0, 2 * ONE_VALUE, ONE_VALUE, '0,
                                  47'h200_0000, 47'h80_0000, '0, '0, 1'b0));
        push_element(make_element(OP_PRIMAL_UPDATE, 3 * ONE_VALUE, ONE_VALUE, -ONE_VALUE, '0,
                                  '0, '0, '0, '0, 1'b0));
        // Constraint update: inside the bounds, clipped high, clipped low
        push_element(make_element(OP_CONSTRAINT_UPDATE, ONE_VALUE, ONE_VALUE, ONE_VALUE, '0,
                                  47'h200_0000, 47'h80_0000, -4 * ONE_VALUE, 4 * ONE_VALUE,
                                  1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, 8 * ONE_VALUE, ONE_VALUE, ONE_VALUE,
                                  '0, 47'h200_0000, 47'h80_0000, -ONE_VALUE, ONE_VALUE, 1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, -8 * ONE_VALUE, ONE_VALUE, -ONE_VALUE,
                                  '0, 47'h200_0000, 47'h80_0000, -ONE_VALUE, ONE_VALUE, 1'b1));
        // Crossed bounds, infinite bounds, zero and mismatched penalties
        push_element(make_element(OP_CONSTRAINT_UPDATE, '0, '0, '0, '0,
                                  47'h100_0000, 47'h100_0000, ONE_VALUE, -ONE_VALUE, 1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, 5 * ONE_VALUE, -ONE_VALUE, ONE_VALUE,
                                  '0, 47'h100_0000, 47'h100_0000, MIN_VALUE, MAX_VALUE, 1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, 2 * ONE_VALUE, ONE_VALUE, ONE_VALUE,
                                  '0, '0, '0, '0, ONE_VALUE >>> 1, 1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, 2 * ONE_VALUE, ONE_VALUE, ONE_VALUE,
                                  '0, 47'h200_0000, 47'h300_0000, '0, ONE_VALUE, 1'b1));
        // Saturation of every path
        push_element(make_element(OP_PRIMAL_RHS, MAX_VALUE, MAX_VALUE, MAX_VALUE, MIN_VALUE,
                                  RATE_MAX, RATE_MAX, MIN_VALUE, MIN_VALUE, 1'b0));
        push_element(make_element(OP_PRIMAL_RHS, MIN_VALUE, MIN_VALUE, MIN_VALUE, MAX_VALUE,
                                  '0, '0, MAX_VALUE, MAX_VALUE, 1'b0));
        push_element(make_element(OP_CONSTRAINT_RHS, MAX_VALUE, MIN_VALUE, MAX_VALUE, '0,
                                  RATE_MAX, RATE_MAX, '0, '0, 1'b0));
        push_element(make_element(OP_CONSTRAINT_RHS, '0, ONE_VALUE, MAX_VALUE, '0,
                                  RATE_MAX, '0, '0, '0, 1'b0));
        push_element(make_element(OP_PRIMAL_UPDATE, MAX_VALUE, MIN_VALUE, MAX_VALUE, '0,
                                  RATE_MAX, RATE_MAX, '0, '0, 1'b0));
        push_element(make_element(OP_PRIMAL_UPDATE, MIN_VALUE, MAX_VALUE, MIN_VALUE, '0,
                                  '0, '0, '0, '0, 1'b1));
        push_element(make_element(OP_CONSTRAINT_UPDATE, MAX_VALUE, MIN_VALUE, MAX_VALUE,
                                  MAX_VALUE, RATE_MAX, RATE_MAX, MIN_VALUE, MAX_VALUE, 1'b0));
        push_element(make_element(OP_CONSTRAINT_UPDATE, MIN_VALUE, MAX_VALUE, MIN_VALUE,
                                  MIN_VALUE, RATE_MAX, RATE_MAX, '0, '0, 1'b0));
        // Products that land exactly on a half, both signs
        push_element(make_element(OP_PRIMAL_RHS, '0, ONE_VALUE >>> 1, '0, '0,
                                  '0, '0, '0, '0, 1'b0));
        push_element(make_element(OP_PRIMAL_RHS, '0, -(ONE_VALUE >>> 1), '0, '0,
                                  '0, '0, '0, '0, 1'b0));
        push_element(make_element(OP_PRIMAL_RHS, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
        run_random_items(50);
        drain_results();

        // Register extremes, unit values, zero alpha, back to reset values, then random settings
        run_phase(25'd1, 33'd1, 60);
        run_phase({ALPHA_WIDTH{1'b1}}, 33'h1_0000_0000, 60);
        run_phase(ALPHA_ONE, 33'h100_0000, 60);
        run_phase('0, {SIGMA_WIDTH{1'b1}}, 60);
        run_phase(ALPHA_RESET, SIGMA_RESET, 50);
        repeat (4)
            run_phase(ALPHA_WIDTH'($urandom),
                      $urandom_range(0, 1) ? SIGMA_WIDTH'($urandom_range(1, 1 << 26))
                                           : SIGMA_WIDTH'({$urandom_range(0, 1), $urandom}),
                      60);

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule : admm_elementwise_update_tb

// File: filelist.f
src/admm_eu_pkg.sv
src/admm_eu_mul.sv
src/admm_elementwise_update.sv
tb/admm_eu_checker.sv
tb/admm_elementwise_update_tb.sv
